// File: src/sliding_window_median_top_defines.svh
// Assertion macros shared by the sliding window median RTL.
// Included by files that check their own logic; needs clk and rst in scope.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// Used by swm_ctrl, swm_datapath and the top level; no dependencies.
package swm_pkg;

  localparam int CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] CFG_RESET_LEN = 7'd5;

  // Controller to datapath commands; each state raises one, ST_HIST two at once.
  typedef struct packed {
    logic load_sample;  // capture input transaction
    logic hist_rd;      // read oldest sample from arrival ring
    logic rm_start;     // clear scan index and match flag
    logic srt_rd;       // read sorted store at scan index
    logic rm_eval;      // removal step on read data
    logic ins_start;    // set up insertion scan
    logic ins_eval;     // insertion step on read data
    logic put;          // place new sample, advance counts
    logic med_lo_rd;    // read lower middle entry
    logic med_hi_rd;    // latch lower, read upper middle entry
    logic out_load;     // load output register
  } swm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;       // fill equals active length
    logic empty;      // nothing held
    logic idx_last;   // scan index at top held entry
    logic idx_zero;   // scan index at bottom
    logic gt;         // read entry above new sample
    logic out_busy;   // result held and not taken this cycle
  } swm_status_t;

endpackage

// File: src/sliding_window_median_top.sv
// Sliding window median, top level: streaming input and output channels
// plus the window length register. Depends on swm_pkg, swm_ctrl, swm_datapath.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one sample per transaction (sample in
//   the low SAMPLE_BITS of s_tdata). Each accepted sample yields one result on
//   m_tvalid/m_tready/m_tdata: lower median in the low half, upper median in
//   the high half; m_tuser is 1 once the window holds its full length.
//   cfg_we/cfg_wdata write the window length (0 acts as 1, values above
//   MAX_WINDOW act as MAX_WINDOW); a write empties the window. Write it only
//   while the block is idle.
//   Timing: removal of the oldest sample runs only once the window is full.
//   s_tready rises with m_tvalid, so the next sample is accepted only after
//   the last one has been placed and its medians read. The single read port
//   of the sorted store paces removal and insertion: each steps through it
//   one entry at a time, a read state then an evaluate state.
//   A finished result sits in the output register while the next sample is
//   processed; if the receiver still stalls when that next result is ready,
//   the block waits for it.
//   Reset: window length returns to 5, window empty, output channel idle.
module sliding_window_median_top #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]        cfg_wdata,   // window_length
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,     // sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,     // lower_median, upper_median
  output logic                                m_tuser      // window_full
);
  import swm_pkg::*;

  swm_cmd_t    cmd;
  swm_status_t status;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swm_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_tdata[SAMPLE_BITS-1:0]),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// File: src/swm_datapath.sv
// Datapath of the sliding window median: sorted store, arrival ring, counters
// and output register. Depends on swm_pkg and the shared assertion macros.
`include "sliding_window_median_top_defines.svh"
module swm_datapath #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [swm_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  swm_pkg::swm_cmd_t                cmd,
  output swm_pkg::swm_status_t             status,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
  output logic                             m_tuser
);
  import swm_pkg::*;

  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int LW  = (CW > CFG_BITS) ? CW : CFG_BITS;
  localparam int MDW = ((2*SAMPLE_BITS+7)/8)*8;

  logic [CFG_BITS-1:0]    win_len_cfg;
  logic [CW-1:0]          len;
  logic [CW-1:0]          fill;
  logic [AW-1:0]          slot;
  logic [AW-1:0]          idx;
  logic [AW-1:0]          pos;
  logic                   found;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] srt_q;
  logic [SAMPLE_BITS-1:0] lo_q;

  logic [SAMPLE_BITS-1:0] srt_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

  logic                   srt_re;
  logic [AW-1:0]          srt_raddr;
  logic                   srt_we;
  logic [AW-1:0]          srt_waddr;
  logic [SAMPLE_BITS-1:0] srt_wdata;
  logic [CW-1:0]          fill_m1;
  logic [CW-1:0]          slot_inc;

  // Clamp the configured length into 1..MAX_WINDOW.
  always_comb begin
    if (win_len_cfg == '0) begin
      len = CW'(1);
    end else if (LW'(win_len_cfg) > LW'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = CW'(win_len_cfg);
    end
  end

  assign fill_m1  = fill - CW'(1);
  assign slot_inc = CW'(slot) + CW'(1);

  assign status.full     = (fill == len);
  assign status.empty    = (fill == '0);
  assign status.idx_last = (CW'(idx) == fill_m1);
  assign status.idx_zero = (idx == '0);
  assign status.gt       = (srt_q > sample_q);
  assign status.out_busy = m_tvalid && !m_tready;

  // Sorted store read address.
  always_comb begin
    srt_re    = cmd.srt_rd || cmd.med_lo_rd || cmd.med_hi_rd;
    srt_raddr = idx;
    if (cmd.med_lo_rd) begin
      srt_raddr = AW'(fill_m1 >> 1);
    end else if (cmd.med_hi_rd) begin
      srt_raddr = AW'(fill >> 1);
    end
  end

  // Sorted store write: shift down on removal, shift up on insertion, place.
  always_comb begin
    srt_we    = 1'b0;
    srt_waddr = pos;
    srt_wdata = sample_q;
    if (cmd.rm_eval && found) begin
      srt_we    = 1'b1;
      srt_waddr = idx - AW'(1);
      srt_wdata = srt_q;
    end else if (cmd.ins_eval && status.gt) begin
      srt_we    = 1'b1;
      srt_waddr = idx + AW'(1);
      srt_wdata = srt_q;
    end else if (cmd.put) begin
      srt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    if (srt_re) begin
      srt_q <= srt_mem[srt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      hist_mem[slot] <= sample_q;
    end
    if (cmd.hist_rd) begin
      old_q <= hist_mem[slot];
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len_cfg <= CFG_RESET_LEN;
      fill        <= '0;
      slot        <= '0;
      found       <= 1'b0;
    end else if (cfg_we) begin
      win_len_cfg <= cfg_wdata;
      fill        <= '0;
      slot        <= '0;
    end else begin
      if (cmd.rm_start) begin
        found <= 1'b0;
      end else if (cmd.rm_eval && !found && srt_q == old_q) begin
        found <= 1'b1;
      end
      if (cmd.rm_eval && status.idx_last) begin
        fill <= fill_m1;
      end else if (cmd.put) begin
        fill <= fill + CW'(1);
      end
      if (cmd.put) begin
        slot <= (slot_inc >= len) ? '0 : AW'(slot_inc);
      end
    end
  end

  // Scan index, insertion position and captured sample.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_q <= sample;
    end
    if (cmd.rm_start) begin
      idx <= '0;
    end else if (cmd.rm_eval && !status.idx_last) begin
      idx <= idx + AW'(1);
    end else if (cmd.ins_start) begin
      idx <= AW'(fill_m1);
      pos <= '0;
    end else if (cmd.ins_eval) begin
      if (!status.gt) begin
        pos <= idx + AW'(1);
      end else if (status.idx_zero) begin
        pos <= '0;
      end else begin
        idx <= idx - AW'(1);
      end
    end
    if (cmd.med_hi_rd) begin
      lo_q <= srt_q;
    end
  end

  // Output register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= MDW'({srt_q, lo_q});
      m_tuser <= status.full;
    end
  end

  `SWM_ASSERT_NOW(a_fill_in_range, 1'b1, fill <= len, "fill count above window length")
  `SWM_ASSERT_NOW(a_slot_in_range, 1'b1, CW'(slot) < len, "write slot outside window")
  `SWM_ASSERT_NOW(a_no_overwrite, cmd.out_load, !status.out_busy,
    "output reloaded while a result waits")

endmodule

// File: src/swm_ctrl.sv
// Controller state machine of the sliding window median: sequences removal,
// insertion and median reads. Depends on swm_pkg and the assertion macros.
`include "sliding_window_median_top_defines.svh"
module swm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t    cmd
);
  import swm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_HIST     = 11'b00000000010,
    ST_RM_RD    = 11'b00000000100,
    ST_RM_EV    = 11'b00000001000,
    ST_INS_INIT = 11'b00000010000,
    ST_INS_RD   = 11'b00000100000,
    ST_INS_EV   = 11'b00001000000,
    ST_PUT      = 11'b00010000000,
    ST_MED_LO   = 11'b00100000000,
    ST_MED_HI   = 11'b01000000000,
    ST_OUT      = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_sample = 1'b1;
          state_next = status.full ? ST_HIST : ST_INS_INIT;
        end
      end
      ST_HIST: begin
        cmd.hist_rd  = 1'b1;
        cmd.rm_start = 1'b1;
        state_next   = ST_RM_RD;
      end
      ST_RM_RD: begin
        cmd.srt_rd = 1'b1;
        state_next = ST_RM_EV;
      end
      ST_RM_EV: begin
        cmd.rm_eval = 1'b1;
        state_next  = status.idx_last ? ST_INS_INIT : ST_RM_RD;
      end
      ST_INS_INIT: begin
        cmd.ins_start = 1'b1;
        state_next    = status.empty ? ST_PUT : ST_INS_RD;
      end
      ST_INS_RD: begin
        cmd.srt_rd = 1'b1;
        state_next = ST_INS_EV;
      end
      ST_INS_EV: begin
        cmd.ins_eval = 1'b1;
        state_next   = (status.gt && !status.idx_zero) ? ST_INS_RD : ST_PUT;
      end
      ST_PUT: begin
        cmd.put    = 1'b1;
        state_next = ST_MED_LO;
      end
      ST_MED_LO: begin
        cmd.med_lo_rd = 1'b1;
        state_next    = ST_MED_HI;
      end
      ST_MED_HI: begin
        cmd.med_hi_rd = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        // hold the medians until the output register frees up
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SWM_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state == ST_HIST ||
    state == ST_INS_INIT, "accepted sample not processed")
  `SWM_ASSERT_NEXT(a_put_then_median, state == ST_PUT, state == ST_MED_LO,
    "median read did not follow placement")

endmodule

// File: tb/sv/sliding_window_median_top_test.sv
// Self-checking testbench for sliding_window_median_top: directed table, then random
// windows of many lengths, each result compared against an in-bench running median or
// a typed table value. Depends on swm_pkg and the sliding_window_median_top RTL only.
module sliding_window_median_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int LEN_BITS     = swm_pkg::CFG_BITS;
  localparam int RANDOM_ITEMS = 1750;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 4 * MAX_WINDOW + 40;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] lower;
    logic [SAMPLE_BITS-1:0] upper;
    logic                   full;
  } median_t;

  typedef enum logic [1:0] {
    ROW_LEN,     // write window length
    ROW_SAMPLE,  // sample, result from the running median
    ROW_TYPED    // sample with its result written out
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [SAMPLE_BITS-1:0] value;
    median_t                want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [LEN_BITS-1:0]   cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;   // sample
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;   // lower_median, upper_median
  logic                  m_tuser;   // window_full

  logic [LEN_BITS-1:0]    len_setting;
  logic [SAMPLE_BITS-1:0] arrivals[$];
  median_t                pending_results[$];
  int                     mismatch_count;
  int                     quiet_cycles;
  int                     src_idle_pct;
  int                     sink_stall_pct;

  dir_row_t directed_rows [29] = '{
    '{ROW_TYPED,  16'hFFFF, '{16'hFFFF, 16'hFFFF, 1'b0}},
    '{ROW_TYPED,  16'h0000, '{16'h0000, 16'hFFFF, 1'b0}},
    '{ROW_SAMPLE, 16'h8000, '0},
    '{ROW_SAMPLE, 16'h0001, '0},
    '{ROW_SAMPLE, 16'h7FFF, '0},
    '{ROW_SAMPLE, 16'h1234, '0},
    '{ROW_SAMPLE, 16'h1234, '0},
    // length zero behaves as one
    '{ROW_LEN,    16'd0,    '0},
    '{ROW_TYPED,  16'hAAAA, '{16'hAAAA, 16'hAAAA, 1'b1}},
    '{ROW_TYPED,  16'h5555, '{16'h5555, 16'h5555, 1'b1}},
    // oversize length clamps to the deepest window
    '{ROW_LEN,    16'd127,  '0},
    '{ROW_SAMPLE, 16'h0001, '0},
    '{ROW_SAMPLE, 16'hFFFE, '0},
    '{ROW_SAMPLE, 16'h0000, '0},
    '{ROW_SAMPLE, 16'hFFFF, '0},
    '{ROW_LEN,    16'd2,    '0},
    '{ROW_TYPED,  16'hFFFF, '{16'hFFFF, 16'hFFFF, 1'b0}},
    '{ROW_TYPED,  16'h0000, '{16'h0000, 16'hFFFF, 1'b1}},
    '{ROW_TYPED,  16'h0000, '{16'h0000, 16'h0000, 1'b1}},
    '{ROW_LEN,    16'd64,   '0},
    '{ROW_SAMPLE, 16'h5A5A, '0},
    '{ROW_SAMPLE, 16'hA5A5, '0},
    '{ROW_SAMPLE, 16'h3C3C, '0},
    '{ROW_SAMPLE, 16'hC3C3, '0},
    '{ROW_LEN,    16'd65,   '0},
    '{ROW_SAMPLE, 16'h0F0F, '0},
    '{ROW_SAMPLE, 16'hF0F0, '0},
    '{ROW_LEN,    16'd1,    '0},
    '{ROW_TYPED,  16'h0F0F, '{16'h0F0F, 16'h0F0F, 1'b1}}
  };

  sliding_window_median_top #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int active_len(logic [LEN_BITS-1:0] setting);
    if (setting == 0) return 1;
    if (setting > MAX_WINDOW) return MAX_WINDOW;
    return int'(setting);
  endfunction

  // Slide the window by one sample and take the two middle values.
  function automatic median_t advance_window(logic [SAMPLE_BITS-1:0] value);
    logic [SAMPLE_BITS-1:0] ordered [MAX_WINDOW];
    int      span;
    int      n;
    int      j;
    median_t r;
    span = active_len(len_setting);
    arrivals.insert(arrivals.size(), value);
    if (arrivals.size() > span) arrivals.delete(0);
    n = arrivals.size();
    for (int i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && ordered[j-1] > arrivals[i]) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = arrivals[i];
    end
    r.lower = ordered[(n - 1) / 2];
    r.upper = ordered[n / 2];
    r.full  = (n == span);
    return r;
  endfunction

  // Call on a falling edge; returns on the falling edge after the transaction.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input bit typed,
                             input median_t want);
    median_t got;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = advance_window(value);
    pending_results.insert(pending_results.size(), typed ? want : got);
    @(negedge clk);
  endtask

  // Hold the input until every outstanding result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_BITS-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we      <= 1'b0;
    len_setting = len;
    arrivals.delete();
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : result_check
    median_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no result, got lower=%h upper=%h full=%b",
                 $time, m_tdata[15:0], m_tdata[31:16], m_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[15:0] !== want.lower) begin
          mismatch_count++;
          $display("%0t: lower_median expected %h got %h", $time, want.lower, m_tdata[15:0]);
        end
        if (m_tdata[31:16] !== want.upper) begin
          mismatch_count++;
          $display("%0t: upper_median expected %h got %h", $time, want.upper, m_tdata[31:16]);
        end
        if (m_tuser !== want.full) begin
          mismatch_count++;
          $display("%0t: window_full expected %b got %b", $time, want.full, m_tuser);
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int                     sent;
    int                     phase;
    int                     seg_items;
    int                     pick;
    logic [LEN_BITS-1:0]    seg_len;
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] value;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 10;
    sink_stall_pct = 72;
    len_setting    = swm_pkg::CFG_RESET_LEN;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      case (directed_rows[k].kind)
        ROW_LEN: begin
          drain_results();
          write_len(directed_rows[k].value[LEN_BITS-1:0]);
        end
        ROW_SAMPLE: send_sample(directed_rows[k].value, 1'b0, '0);
        default:    send_sample(directed_rows[k].value, 1'b1, directed_rows[k].want);
      endcase
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase = sent * 3 / RANDOM_ITEMS;
      case (phase)
        0: begin
          src_idle_pct   = 10;
          sink_stall_pct = 72;
        end
        1: begin
          src_idle_pct   = 72;
          sink_stall_pct = 10;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      // Mostly short windows; deep or oversize ones now and then.
      if ($urandom_range(0, 9) == 0) seg_len = LEN_BITS'($urandom_range(60, 127));
      else seg_len = LEN_BITS'($urandom_range(0, 12));
      drain_results();
      write_len(seg_len);
      seg_items = active_len(seg_len) + int'($urandom_range(8, 30));
      base      = SAMPLE_BITS'($urandom_range(0, 16'hFFFC));
      for (int i = 0; i < seg_items; i++) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 6) value = SAMPLE_BITS'($urandom_range(0, 16'hFFFF));
        else if (pick < 9) value = base + SAMPLE_BITS'($urandom_range(0, 3));  // force ties
        else value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        send_sample(value, 1'b0, '0);
        sent++;
      end
    end

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
